@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the escape encoder RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every clock edge outside reset
`define SEC_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// check that a condition implies a consequence in the same cycle
`define SEC_ASSERT_IMPLY(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ rtl/sec_pkg.sv @@
// ----------------------------------------------------------------------------
// sec_pkg
// Types, character constants and helper functions for the escape encoder
// ----------------------------------------------------------------------------
package sec_pkg;

    // most escaped bytes one input transaction can produce
    localparam int MAX_OUT   = 6;
    localparam int ESC_LEN   = 4;
    localparam int CNT_W     = $clog2(MAX_OUT + 1);
    localparam int IDX_W     = $clog2(MAX_OUT);
    localparam int ESC_IDX_W = $clog2(ESC_LEN);

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] PRINT_LO  = 8'd32;
    localparam logic [7:0] PRINT_HI  = 8'd126;
    localparam logic [3:0] NIB_TEN   = 4'd10;

    typedef logic [7:0] byte_t;

    // expanded form of one input transaction
    typedef struct packed {
        byte_t [MAX_OUT-1:0] bytes;
        logic  [CNT_W-1:0]   cnt;
        logic                last;
    } sec_exp_t;

    // one hex digit from a nibble
    function automatic byte_t nibble_hex(input logic [3:0] nib, input logic upper);
        byte_t base;
        base = upper ? CH_UP_A : CH_LO_A;
        if (nib < NIB_TEN) begin
            return CH_ZERO + {4'h0, nib};
        end
        return base + {4'h0, nib - NIB_TEN};
    endfunction

endpackage

@@ rtl/sec_expand.sv @@
// ----------------------------------------------------------------------------
// sec_expand
// Turns one raw byte with its string marks into the escaped byte sequence
// ----------------------------------------------------------------------------
module sec_expand import sec_pkg::*; (
    input  logic     hex_uppercase,
    input  logic [7:0] in_byte,
    input  logic     first_byte,
    input  logic     last_byte,
    input  logic     add_quotes,
    input  logic     empty_string,
    output sec_exp_t expanded
);

    logic                 first_eff;
    logic                 last_eff;
    logic                 q_open;
    logic                 q_close;
    logic                 named;
    byte_t                letter;
    byte_t [ESC_LEN-1:0]  esc;
    logic  [CNT_W-1:0]    esc_len;

    // named escape decoder
    always_comb begin
        named  = 1'b1;
        letter = in_byte;
        unique case (in_byte)
            CH_BSLASH, CH_DQUOTE, CH_SQUOTE: letter = in_byte;
            8'd10:  letter = 8'h6E; // n
            8'd13:  letter = 8'h72; // r
            8'd9:   letter = 8'h74; // t
            8'd12:  letter = 8'h66; // f
            8'd0:   letter = 8'h30; // 0
            8'd8:   letter = 8'h62; // b
            8'd7:   letter = 8'h61; // a
            8'd11:  letter = 8'h76; // v
            CH_ESC: letter = 8'h65; // e
            default: named = 1'b0;
        endcase
    end

    // escape body; unused slots hold a double quote so the closing quote
    // lands right after the body without a separate mux
    always_comb begin
        first_eff = empty_string | first_byte;
        last_eff  = empty_string | last_byte;
        q_open    = first_eff & add_quotes;
        q_close   = last_eff & add_quotes;
        for (int k = 0; k < ESC_LEN; k++) begin
            esc[k] = CH_DQUOTE;
        end
        if (empty_string) begin
            esc_len = CNT_W'(0);
        end else if (named) begin
            esc_len = CNT_W'(2);
            esc[0]  = CH_BSLASH;
            esc[1]  = letter;
        end else if (in_byte < PRINT_LO || in_byte > PRINT_HI) begin
            esc_len = CNT_W'(4);
            esc[0]  = CH_BSLASH;
            esc[1]  = CH_X;
            esc[2]  = nibble_hex(in_byte[7:4], hex_uppercase);
            esc[3]  = nibble_hex(in_byte[3:0], hex_uppercase);
        end else begin
            esc_len = CNT_W'(1);
            esc[0]  = in_byte;
        end
    end

    // place the body after the optional opening quote
    always_comb begin
        for (int i = 0; i < MAX_OUT; i++) begin
            expanded.bytes[i] = CH_DQUOTE;
            if (q_open) begin
                if (i >= 1 && i <= ESC_LEN) begin
                    expanded.bytes[i] = esc[ESC_IDX_W'(i - 1)];
                end
            end else if (i < ESC_LEN) begin
                expanded.bytes[i] = esc[ESC_IDX_W'(i)];
            end
        end
        expanded.cnt  = {{(CNT_W-1){1'b0}}, q_open} + esc_len
                      + {{(CNT_W-1){1'b0}}, q_close};
        expanded.last = last_eff;
    end

endmodule

@@ rtl/string_escape_encoder_core.sv @@
// ----------------------------------------------------------------------------
// string_escape_encoder_core
// C string literal escaper: one raw byte in, its escaped bytes out one by one
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      in_byte, first/last, quotes, empty
//  m_        out        m_valid / m_ready      out_byte, last_of_item, end_of_string
//  cfg_      in         cfg_valid / cfg_ready  hex_uppercase in cfg_data[0]
//
//  An item of n escaped bytes (0 to 6) holds the item register until all n
//  bytes have gone to the output register, which delivers one byte per cycle
//  while m_ready allows; items that escape to a single byte flow at one per
//  cycle through the item and output registers. Items that produce no byte
//  are taken and dropped. Reset is synchronous on aresetn low; it empties both
//  registers and clears hex_uppercase. A stall on m_ready holds the output byte
//  and the item register; s_ready stays high while the item register is free.
// ----------------------------------------------------------------------------
module string_escape_encoder_core import sec_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input transactions
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_first_byte,
    input  logic       s_last_byte,
    input  logic       s_add_quotes,
    input  logic       s_empty_string,
    // result transactions
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_last_of_item,
    output logic       m_end_of_string,
    // configuration
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data
);

    `include "assert_macros.svh"

    logic                 hex_uppercase_reg;
    sec_exp_t             expanded;

    logic                 a_valid_reg;
    byte_t [MAX_OUT-1:0]  a_bytes_reg;
    logic  [CNT_W-1:0]    a_cnt_reg;
    logic  [IDX_W-1:0]    a_idx_reg;
    logic                 a_last_reg;

    logic                 m_valid_reg;
    byte_t                m_byte_reg;
    logic                 m_last_item_reg;
    logic                 m_end_reg;

    logic                 out_load;
    logic  [CNT_W-1:0]    a_idx_ext;
    logic                 a_final;
    logic                 s_accept;

    // configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hex_uppercase_reg <= 1'b0;
        end else if (cfg_valid) begin
            hex_uppercase_reg <= cfg_data;
        end
    end

    // escape expansion of the incoming transaction
    sec_expand u_expand (
        .hex_uppercase (hex_uppercase_reg),
        .in_byte       (s_in_byte),
        .first_byte    (s_first_byte),
        .last_byte     (s_last_byte),
        .add_quotes    (s_add_quotes),
        .empty_string  (s_empty_string),
        .expanded      (expanded)
    );

    // handshake control
    assign out_load  = !m_valid_reg || m_ready;
    assign a_idx_ext = CNT_W'(a_idx_reg);
    assign a_final   = (a_idx_ext == a_cnt_reg - CNT_W'(1));
    assign s_ready   = !a_valid_reg || (out_load && a_final);
    assign s_accept  = s_valid && s_ready;

    // item register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_idx_reg   <= '0;
        end else if (s_accept) begin
            a_valid_reg <= (expanded.cnt != CNT_W'(0));
            a_idx_reg   <= '0;
        end else if (a_valid_reg && out_load) begin
            if (a_final) begin
                a_valid_reg <= 1'b0;
            end else begin
                a_idx_reg <= a_idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_bytes_reg <= expanded.bytes;
            a_cnt_reg   <= expanded.cnt;
            a_last_reg  <= expanded.last;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg      <= a_bytes_reg[a_idx_reg];
            m_last_item_reg <= a_final;
            m_end_reg       <= a_final && a_last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_last_of_item  = m_last_item_reg;
    assign m_end_of_string = m_end_reg;

    // assertions
    `SEC_ASSERT_IMPLY(a_cnt_nonzero, a_valid_reg, a_cnt_reg != CNT_W'(0), "held item has no bytes")
    `SEC_ASSERT_IMPLY(a_idx_in_range, a_valid_reg, a_idx_ext < a_cnt_reg, "byte index past item end")
    `SEC_ASSERT_IMPLY(end_implies_last, m_valid && m_end_of_string, m_last_of_item, "end not last")
    `SEC_ASSERT_ALWAYS(free_means_ready, a_valid_reg || s_ready, "free item register not ready")

endmodule
